// File: hw/rtl/fpbc_pkg.sv
// Shared codes, widths and Q16 ratio thresholds for the face pose bin classifier.
package fpbc_pkg;

  // Result field widths
  localparam int unsigned DIR_W   = 2;
  localparam int unsigned ANGLE_W = 7;

  // Direction codes
  localparam logic [DIR_W-1:0] TURN_NONE  = 2'd0;
  localparam logic [DIR_W-1:0] TURN_LEFT  = 2'd1;
  localparam logic [DIR_W-1:0] TURN_RIGHT = 2'd2;
  localparam logic [DIR_W-1:0] TILT_NONE  = 2'd0;
  localparam logic [DIR_W-1:0] TILT_UP    = 2'd1;
  localparam logic [DIR_W-1:0] TILT_DOWN  = 2'd2;

  // Angle bins step by fifteen degrees
  localparam int unsigned ANGLE_STEP = 15;

  // Ratios are Q16 fixed point
  localparam int unsigned Q_SHIFT = 16;
  localparam int unsigned THR_W   = 16;

  localparam int unsigned N_TURN = 5;
  localparam int unsigned N_VERT = 6;

  // Horizontal: 0.6, 0.45, 0.3, 0.2, 0.1
  localparam logic [THR_W-1:0] TURN_THR [N_TURN] = '{
    16'd39322, 16'd29491, 16'd19661, 16'd13107, 16'd6554
  };
  // Downward tilt: 0.25, 0.21, 0.17, 0.13, 0.09, 0.04
  localparam logic [THR_W-1:0] DOWN_THR [N_VERT] = '{
    16'd16384, 16'd13763, 16'd11141, 16'd8520, 16'd5898, 16'd2621
  };
  // Upward tilt: 0.2, 0.16, 0.12, 0.08, 0.04, 0.01
  localparam logic [THR_W-1:0] UP_THR [N_VERT] = '{
    16'd13107, 16'd10486, 16'd7864, 16'd5243, 16'd2621, 16'd655
  };

endpackage

// File: hw/rtl/fpbc_lmk_if.sv
// Landmark channel: five face points with valid/ready handshake.
interface fpbc_lmk_if #(
  parameter int unsigned COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] left_eye_x;
  logic [COORD_BITS-1:0] left_eye_y;
  logic [COORD_BITS-1:0] right_eye_x;
  logic [COORD_BITS-1:0] right_eye_y;
  logic [COORD_BITS-1:0] nose_x;
  logic [COORD_BITS-1:0] nose_y;
  logic [COORD_BITS-1:0] mouth_left_x;
  logic [COORD_BITS-1:0] mouth_left_y;
  logic [COORD_BITS-1:0] mouth_right_x;
  logic [COORD_BITS-1:0] mouth_right_y;

  modport source (
    output valid, left_eye_x, left_eye_y, right_eye_x, right_eye_y, nose_x, nose_y,
           mouth_left_x, mouth_left_y, mouth_right_x, mouth_right_y,
    input  ready
  );
  modport sink (
    input  valid, left_eye_x, left_eye_y, right_eye_x, right_eye_y, nose_x, nose_y,
           mouth_left_x, mouth_left_y, mouth_right_x, mouth_right_y,
    output ready
  );
endinterface

// File: hw/rtl/fpbc_pose_if.sv
// Pose channel: binned head pose result with valid/ready handshake.
interface fpbc_pose_if;
  logic                          valid;
  logic                          ready;
  logic                          landmarks_valid;
  logic [fpbc_pkg::DIR_W-1:0]    turn_direction;
  logic [fpbc_pkg::ANGLE_W-1:0]  turn_angle;
  logic [fpbc_pkg::DIR_W-1:0]    tilt_direction;
  logic [fpbc_pkg::ANGLE_W-1:0]  tilt_angle;
  logic                          looking_straight;

  modport source (
    output valid, landmarks_valid, turn_direction, turn_angle, tilt_direction,
           tilt_angle, looking_straight,
    input  ready
  );
  modport sink (
    input  valid, landmarks_valid, turn_direction, turn_angle, tilt_direction,
           tilt_angle, looking_straight,
    output ready
  );
endinterface

// File: hw/rtl/face_pose_bin_classifier.sv
// Head pose classifier: six-stage pipeline from five landmarks to pose bins.
// The six register stages midpoint, difference, square, sum, product and compare/bin
// run in that order; a landmark transfer loads the first, the last drives pose valid.
// Throughput: one landmark set per cycle; each stage holds while the one after
// it is full and stalled, so pose ready back-pressures through to landmark ready.
// Reset clears the stage valid bits only; payload registers are not reset.
module face_pose_bin_classifier #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fpbc_lmk_if.sink       lmk_i,
  fpbc_pose_if.source    pose_o
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * CB;
  localparam int unsigned D_W   = 2 * CB + 1;
  localparam int unsigned P_W   = D_W + fpbc_pkg::THR_W;
  localparam int unsigned X_W   = 2 * D_W;
  localparam int unsigned NDIST = 6;
  localparam int unsigned NST   = 6;

  // Distance slots
  localparam int unsigned DLE = 0;  // nose to left eye
  localparam int unsigned DRE = 1;  // nose to right eye
  localparam int unsigned DME = 2;  // eye midpoint to nose
  localparam int unsigned DMM = 3;  // mouth midpoint to nose
  localparam int unsigned DMO = 4;  // mouth width
  localparam int unsigned DEY = 5;  // eye distance

  // Bin a ratio: above the first threshold gives zero, else the first met index
  function automatic logic [fpbc_pkg::ANGLE_W-1:0] bin_angle(
    input logic                        above,
    input logic [fpbc_pkg::N_VERT-1:0] ge_vec,
    input int unsigned                 n
  );
    logic [fpbc_pkg::ANGLE_W-1:0] ang;
    ang = fpbc_pkg::ANGLE_W'(fpbc_pkg::ANGLE_STEP * n);
    for (int i = fpbc_pkg::N_VERT - 1; i >= 1; i--) begin
      if ((i < n) && ge_vec[i]) begin
        ang = fpbc_pkg::ANGLE_W'(fpbc_pkg::ANGLE_STEP * i);
      end
    end
    if (above) begin
      ang = '0;
    end
    return ang;
  endfunction

  function automatic logic [CB-1:0] abs_diff(input logic [CB-1:0] a, input logic [CB-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Stage valid bits and enables
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || pose_o.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign lmk_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= lmk_i.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 1: latch points, form floored midpoints and the profile tests
  logic [CB-1:0] lex_q, ley_q, rex_q, rey_q, nx_q, ny_q;
  logic [CB-1:0] mlx_q, mly_q, mrx_q, mry_q;
  logic [CB-1:0] mex_q, mey_q, mmx_q, mmy_q;
  logic          ok1_q, tl1_q, tr1_q;
  logic [CB:0]   sum_ex, sum_ey, sum_mx, sum_my;

  assign sum_ex = {1'b0, lmk_i.left_eye_x} + {1'b0, lmk_i.right_eye_x};
  assign sum_ey = {1'b0, lmk_i.left_eye_y} + {1'b0, lmk_i.right_eye_y};
  assign sum_mx = {1'b0, lmk_i.mouth_left_x} + {1'b0, lmk_i.mouth_right_x};
  assign sum_my = {1'b0, lmk_i.mouth_left_y} + {1'b0, lmk_i.mouth_right_y};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      lex_q <= lmk_i.left_eye_x;
      ley_q <= lmk_i.left_eye_y;
      rex_q <= lmk_i.right_eye_x;
      rey_q <= lmk_i.right_eye_y;
      nx_q  <= lmk_i.nose_x;
      ny_q  <= lmk_i.nose_y;
      mlx_q <= lmk_i.mouth_left_x;
      mly_q <= lmk_i.mouth_left_y;
      mrx_q <= lmk_i.mouth_right_x;
      mry_q <= lmk_i.mouth_right_y;
      mex_q <= sum_ex[CB:1];
      mey_q <= sum_ey[CB:1];
      mmx_q <= sum_mx[CB:1];
      mmy_q <= sum_my[CB:1];
      ok1_q <= (lmk_i.left_eye_x != '0);
      tl1_q <= (lmk_i.nose_x <= lmk_i.left_eye_x) && (lmk_i.nose_x <= lmk_i.mouth_left_x);
      tr1_q <= (lmk_i.nose_x >= lmk_i.right_eye_x) && (lmk_i.nose_x >= lmk_i.mouth_right_x);
    end
  end

  // Stage 2: absolute coordinate differences for every distance
  logic [CB-1:0] adx_q [NDIST];
  logic [CB-1:0] ady_q [NDIST];
  logic          ok2_q, tl2_q, tr2_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      adx_q[DLE] <= abs_diff(nx_q, lex_q);
      ady_q[DLE] <= abs_diff(ny_q, ley_q);
      adx_q[DRE] <= abs_diff(nx_q, rex_q);
      ady_q[DRE] <= abs_diff(ny_q, rey_q);
      adx_q[DME] <= abs_diff(mex_q, nx_q);
      ady_q[DME] <= abs_diff(mey_q, ny_q);
      adx_q[DMM] <= abs_diff(mmx_q, nx_q);
      ady_q[DMM] <= abs_diff(mmy_q, ny_q);
      adx_q[DMO] <= abs_diff(mlx_q, mrx_q);
      ady_q[DMO] <= abs_diff(mly_q, mry_q);
      adx_q[DEY] <= abs_diff(lex_q, rex_q);
      ady_q[DEY] <= abs_diff(ley_q, rey_q);
      ok2_q <= ok1_q;
      tl2_q <= tl1_q;
      tr2_q <= tr1_q;
    end
  end

  // Stage 3: square the differences
  logic [SQ_W-1:0] sqx_q [NDIST];
  logic [SQ_W-1:0] sqy_q [NDIST];
  logic            ok3_q, tl3_q, tr3_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int k = 0; k < NDIST; k++) begin
        sqx_q[k] <= SQ_W'(adx_q[k]) * SQ_W'(adx_q[k]);
        sqy_q[k] <= SQ_W'(ady_q[k]) * SQ_W'(ady_q[k]);
      end
      ok3_q <= ok2_q;
      tl3_q <= tl2_q;
      tr3_q <= tr2_q;
    end
  end

  // Stage 4: sum into squared distances
  logic [D_W-1:0] dist_q [NDIST];
  logic           ok4_q, tl4_q, tr4_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int k = 0; k < NDIST; k++) begin
        dist_q[k] <= D_W'(sqx_q[k]) + D_W'(sqy_q[k]);
      end
      ok4_q <= ok3_q;
      tl4_q <= tl3_q;
      tr4_q <= tr3_q;
    end
  end

  // Stage 5: threshold products and the eye-versus-mouth cross products
  logic [P_W-1:0] tle_q  [fpbc_pkg::N_TURN];
  logic [P_W-1:0] tre_q  [fpbc_pkg::N_TURN];
  logic [P_W-1:0] down_q [fpbc_pkg::N_VERT];
  logic [P_W-1:0] up_q   [fpbc_pkg::N_VERT];
  logic [X_W-1:0] xeye_q, xmouth_q;
  logic [D_W-1:0] dle_q, dre_q, dme_q, dmm_q;
  logic           lge_q, ok5_q, tl5_q, tr5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int i = 0; i < fpbc_pkg::N_TURN; i++) begin
        tle_q[i] <= P_W'(fpbc_pkg::TURN_THR[i]) * P_W'(dist_q[DLE]);
        tre_q[i] <= P_W'(fpbc_pkg::TURN_THR[i]) * P_W'(dist_q[DRE]);
      end
      for (int i = 0; i < fpbc_pkg::N_VERT; i++) begin
        down_q[i] <= P_W'(fpbc_pkg::DOWN_THR[i]) * P_W'(dist_q[DMO]);
        up_q[i]   <= P_W'(fpbc_pkg::UP_THR[i]) * P_W'(dist_q[DEY]);
      end
      xeye_q   <= X_W'(dist_q[DME]) * X_W'(dist_q[DMO]);
      xmouth_q <= X_W'(dist_q[DMM]) * X_W'(dist_q[DEY]);
      dle_q    <= dist_q[DLE];
      dre_q    <= dist_q[DRE];
      dme_q    <= dist_q[DME];
      dmm_q    <= dist_q[DMM];
      lge_q    <= (dist_q[DLE] >= dist_q[DRE]);
      ok5_q    <= ok4_q;
      tl5_q    <= tl4_q;
      tr5_q    <= tr4_q;
    end
  end

  // Stage 6: compare against thresholds and bin
  logic [P_W-1:0]                turn_lhs, down_lhs, up_lhs;
  logic [fpbc_pkg::N_VERT-1:0]   turn_ge, down_ge, up_ge;
  logic                          turn_above, down_above, up_above;
  logic [fpbc_pkg::ANGLE_W-1:0]  turn_bin, tilt_bin;
  logic [fpbc_pkg::DIR_W-1:0]    tdir_d, vdir_d;
  logic [fpbc_pkg::ANGLE_W-1:0]  tang_d, vang_d;
  logic                          is_down;

  always_comb begin
    turn_lhs = lge_q ? {dre_q, fpbc_pkg::Q_SHIFT'(0)} : {dle_q, fpbc_pkg::Q_SHIFT'(0)};
    down_lhs = {dmm_q, fpbc_pkg::Q_SHIFT'(0)};
    up_lhs   = {dme_q, fpbc_pkg::Q_SHIFT'(0)};
    turn_ge  = '0;
    for (int i = 0; i < fpbc_pkg::N_TURN; i++) begin
      turn_ge[i] = turn_lhs >= (lge_q ? tle_q[i] : tre_q[i]);
    end
    turn_above = turn_lhs > (lge_q ? tle_q[0] : tre_q[0]);
    for (int i = 0; i < fpbc_pkg::N_VERT; i++) begin
      down_ge[i] = down_lhs >= down_q[i];
      up_ge[i]   = up_lhs >= up_q[i];
    end
    down_above = down_lhs > down_q[0];
    up_above   = up_lhs > up_q[0];
    is_down    = xeye_q > xmouth_q;

    turn_bin = bin_angle(turn_above, turn_ge, fpbc_pkg::N_TURN);
    tilt_bin = is_down ? bin_angle(down_above, down_ge, fpbc_pkg::N_VERT)
                       : bin_angle(up_above, up_ge, fpbc_pkg::N_VERT);

    // Horizontal: profile cases first, then the eye-to-nose ratio
    if (tl5_q) begin
      tdir_d = fpbc_pkg::TURN_LEFT;
      tang_d = fpbc_pkg::ANGLE_W'(fpbc_pkg::ANGLE_STEP * fpbc_pkg::N_VERT);
    end else if (tr5_q) begin
      tdir_d = fpbc_pkg::TURN_RIGHT;
      tang_d = fpbc_pkg::ANGLE_W'(fpbc_pkg::ANGLE_STEP * fpbc_pkg::N_VERT);
    end else begin
      tang_d = turn_bin;
      if (turn_bin == '0) tdir_d = fpbc_pkg::TURN_NONE;
      else if (lge_q)     tdir_d = fpbc_pkg::TURN_RIGHT;
      else                tdir_d = fpbc_pkg::TURN_LEFT;
    end

    // Vertical
    vang_d = tilt_bin;
    if (tilt_bin == '0) vdir_d = fpbc_pkg::TILT_NONE;
    else if (is_down)   vdir_d = fpbc_pkg::TILT_DOWN;
    else                vdir_d = fpbc_pkg::TILT_UP;

    // Drop everything for missing landmarks
    if (!ok5_q) begin
      tdir_d = fpbc_pkg::TURN_NONE;
      tang_d = '0;
      vdir_d = fpbc_pkg::TILT_NONE;
      vang_d = '0;
    end
  end

  logic                          lv_q, straight_q;
  logic [fpbc_pkg::DIR_W-1:0]    tdir_q, vdir_q;
  logic [fpbc_pkg::ANGLE_W-1:0]  tang_q, vang_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      lv_q       <= ok5_q;
      tdir_q     <= tdir_d;
      tang_q     <= tang_d;
      vdir_q     <= vdir_d;
      vang_q     <= vang_d;
      straight_q <= ok5_q && (tdir_d == fpbc_pkg::TURN_NONE) && (vdir_d == fpbc_pkg::TILT_NONE);
    end
  end

  // Drive the result transfer
  assign pose_o.valid            = v_q[NST-1];
  assign pose_o.landmarks_valid  = lv_q;
  assign pose_o.turn_direction   = tdir_q;
  assign pose_o.turn_angle       = tang_q;
  assign pose_o.tilt_direction   = vdir_q;
  assign pose_o.tilt_angle       = vang_q;
  assign pose_o.looking_straight = straight_q;

endmodule
